// ===== rtl/sql_word_classifier_defines.svh =====
// assertion helpers for the word classifier
`ifndef SQL_WORD_CLASSIFIER_DEFINES_SVH
`define SQL_WORD_CLASSIFIER_DEFINES_SVH

// same-cycle implication, sampled on clk, idle during rst
`define SWC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swc assertion failed");

// next-cycle implication, sampled on clk, idle during rst
`define SWC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swc assertion failed");

`endif

// ===== rtl/swc_pkg.sv =====
`default_nettype none
package swc_pkg;

  localparam int NUM_FIXED = 13;
  localparam int FIXED_MAX_LEN = 8;
  localparam logic [NUM_FIXED-1:0] ALL_CAND = '1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  typedef enum logic [3:0] {
    CLS_NONE    = 4'd0,
    CLS_KEYWORD = 4'd1,
    CLS_VALUE   = 4'd2,
    CLS_LT      = 4'd3,
    CLS_GT      = 4'd4,
    CLS_LE      = 4'd5,
    CLS_GE      = 4'd6,
    CLS_EQ      = 4'd7,
    CLS_NE      = 4'd8,
    CLS_LPAREN  = 4'd9,
    CLS_RPAREN  = 4'd10
  } token_class_t;

  typedef struct packed {
    logic                 in_word;
    logic [NUM_FIXED-1:0] mask;
  } cand_t;

  localparam logic [7:0] FIXED_TEXT [NUM_FIXED][FIXED_MAX_LEN] = '{
    '{"C", "R", "E", "A", "T", "E", 8'h00, 8'h00},
    '{"I", "N", "S", "E", "R", "T", 8'h00, 8'h00},
    '{"S", "E", "L", "E", "C", "T", 8'h00, 8'h00},
    '{"T", "A", "B", "L", "E", 8'h00, 8'h00, 8'h00},
    '{"D", "A", "T", "A", "B", "A", "S", "E"},
    '{"<", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{">", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"<", "=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{">", "=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"!", "=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"(", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{")", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [3:0] FIXED_LEN [NUM_FIXED] = '{
    4'd6, 4'd6, 4'd6, 4'd5, 4'd8, 4'd1, 4'd1, 4'd2, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1
  };

  localparam logic FIXED_FOLD [NUM_FIXED] = '{
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
  };

  localparam token_class_t FIXED_CLASS [NUM_FIXED] = '{
    CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD,
    CLS_LT, CLS_GT, CLS_LE, CLS_GE, CLS_EQ, CLS_NE, CLS_LPAREN, CLS_RPAREN
  };

endpackage
`default_nettype wire

// ===== rtl/swc_match.sv =====
`default_nettype none
module swc_match import swc_pkg::*; #(
  parameter int MAX_STATEMENT = 4096,
  localparam int LEN_W = $clog2(MAX_STATEMENT + 1)
) (
  input  wire logic [7:0]           ch,
  input  wire logic                 take,
  input  wire cand_t                cand,
  input  wire logic [LEN_W-1:0]     word_len,
  output logic [NUM_FIXED-1:0]      eff_mask,
  output logic [LEN_W-1:0]          eff_len,
  output token_class_t              eff_class
);

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_STATEMENT);

  logic [7:0]           up;
  logic [NUM_FIXED-1:0] base_mask;
  logic [LEN_W-1:0]     base_len;
  logic [NUM_FIXED-1:0] keep;

  assign up = (ch >= CH_LOW_A && ch <= CH_LOW_Z) ? ch - CASE_GAP : ch;
  assign base_mask = cand.in_word ? cand.mask : ALL_CAND;
  assign base_len  = cand.in_word ? word_len : '0;

  // a candidate survives if it is still long enough and the next character agrees
  always_comb begin
    for (int k = 0; k < NUM_FIXED; k++) begin
      keep[k] = base_mask[k]
             && (base_len < LEN_W'(FIXED_LEN[k]))
             && (FIXED_TEXT[k][base_len[2:0]] == (FIXED_FOLD[k] ? up : ch));
    end
  end

  assign eff_mask = take ? keep : cand.mask;

  always_comb begin
    if (!take) begin
      eff_len = word_len;
    end else if (base_len < LEN_MAX) begin
      eff_len = base_len + LEN_W'(1);
    end else begin
      eff_len = base_len;
    end
  end

  // first surviving fixed word of the exact length wins
  always_comb begin
    logic found;
    found = 1'b0;
    eff_class = CLS_VALUE;
    for (int k = 0; k < NUM_FIXED; k++) begin
      if (!found && eff_mask[k] && eff_len == LEN_W'(FIXED_LEN[k])) begin
        found = 1'b1;
        eff_class = FIXED_CLASS[k];
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sql_word_classifier.sv =====
// path: a byte is registered in the input register on acceptance; its token, if any,
//   moves into the result register once the result register is free to take it
// throughput: one byte per cycle, limited only by the result register draining
// reset: rst is synchronous, active high; clears the pipeline valids and all
//   word and position state; payload registers are not reset
`default_nettype none
`include "sql_word_classifier_defines.svh"
module sql_word_classifier import swc_pkg::*; #(
  parameter int MAX_STATEMENT = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  ch,
  input  wire logic        is_last_byte,
  input  wire logic        is_empty,
  output logic             token_valid,
  input  wire logic        token_stall,
  output logic [3:0]       token_class,
  output logic [11:0]      token_start,
  output logic [12:0]      token_length,
  output logic             end_of_statement
);

  localparam int POS_W = $clog2(MAX_STATEMENT);
  localparam int LEN_W = $clog2(MAX_STATEMENT + 1);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_STATEMENT - 1);

  // input register
  logic       s1_valid;
  logic [7:0] s1_ch;
  logic       s1_last;
  logic       s1_empty;

  // statement state
  logic                 in_word;
  logic [POS_W-1:0]     word_start;
  logic [LEN_W-1:0]     word_len;
  logic [POS_W-1:0]     byte_pos;
  logic [NUM_FIXED-1:0] cand_mask;

  logic                 advance;
  logic                 s1_ready;
  logic                 is_space;
  logic                 take;
  logic                 emit;
  logic                 emit_word;
  logic [POS_W-1:0]     eff_start;
  logic [NUM_FIXED-1:0] eff_mask;
  logic [LEN_W-1:0]     eff_len;
  token_class_t         eff_class;
  cand_t                cand;
  logic [31:0]          start_ext;
  logic [31:0]          len_ext;

  assign advance    = s1_valid && (!token_valid || !token_stall);
  assign s1_ready   = !s1_valid || advance;
  assign byte_stall = !s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= byte_valid;
    end
    if (s1_ready && byte_valid) begin
      s1_ch    <= ch;
      s1_last  <= is_last_byte;
      s1_empty <= is_empty;
    end
  end

  assign is_space = (s1_ch == CH_SPACE);
  // a trailing semicolon is dropped, spaces never join a word
  assign take = !s1_empty && !is_space && !(s1_last && s1_ch == CH_SEMI);
  assign emit = s1_empty || s1_last || (is_space && in_word);
  assign emit_word = !s1_empty && (in_word || take);
  assign eff_start = in_word ? word_start : byte_pos;

  assign cand.in_word = in_word;
  assign cand.mask    = cand_mask;

  swc_match #(
    .MAX_STATEMENT(MAX_STATEMENT)
  ) u_match (
    .ch        (s1_ch),
    .take      (take),
    .cand      (cand),
    .word_len  (word_len),
    .eff_mask  (eff_mask),
    .eff_len   (eff_len),
    .eff_class (eff_class)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_word    <= 1'b0;
      word_start <= '0;
      word_len   <= '0;
      byte_pos   <= '0;
      cand_mask  <= ALL_CAND;
    end else if (advance) begin
      if (s1_empty || s1_last) begin
        in_word    <= 1'b0;
        word_start <= '0;
        word_len   <= '0;
        byte_pos   <= '0;
        cand_mask  <= ALL_CAND;
      end else begin
        if (is_space) begin
          in_word   <= 1'b0;
          word_len  <= '0;
          cand_mask <= ALL_CAND;
        end else begin
          in_word    <= 1'b1;
          word_start <= eff_start;
          word_len   <= eff_len;
          cand_mask  <= eff_mask;
        end
        if (byte_pos < POS_LAST) begin
          byte_pos <= byte_pos + POS_W'(1);
        end
      end
    end
  end

  assign start_ext = 32'(eff_start);
  assign len_ext   = 32'(eff_len);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
    end else if (advance) begin
      token_valid <= emit;
    end else if (!token_stall) begin
      token_valid <= 1'b0;
    end
    if (advance && emit) begin
      token_class      <= emit_word ? eff_class : CLS_NONE;
      token_start      <= emit_word ? start_ext[11:0] : 12'd0;
      token_length     <= emit_word ? len_ext[12:0] : 13'd0;
      end_of_statement <= s1_empty || s1_last;
    end
  end

  `SWC_ASSERT_IMPL(a_none_only_at_end,
    token_valid && token_class == CLS_NONE, end_of_statement)
  `SWC_ASSERT_IMPL(a_none_is_blank,
    token_valid && token_class == CLS_NONE, token_start == 12'd0 && token_length == 13'd0)
  `SWC_ASSERT_IMPL(a_word_not_empty,
    token_valid && !end_of_statement, token_length != 13'd0)
  `SWC_ASSERT_NEXT(a_end_clears_state,
    advance && (s1_empty || s1_last), !in_word && byte_pos == '0)

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

import swc_pkg::*;

class token_scoreboard;
  localparam int MAX_STMT = 4096;
  localparam int N_FIXED = 13;

  typedef struct {
    token_class_t cls;
    logic [11:0]  start;
    logic [12:0]  length;
    logic         eos;
  } token_rec_t;

  string        fixed_text [N_FIXED];
  bit           fixed_fold [N_FIXED];
  token_class_t fixed_cls  [N_FIXED];

  // running statement state
  bit           in_word;
  logic [11:0]  word_start;
  logic [12:0]  word_len;
  logic [11:0]  byte_pos;
  logic [12:0]  cand;

  token_rec_t   expected_tokens[$];
  int           mismatches;
  int           checked;
  int           class_hits[11];

  function new();
    fixed_text = '{"CREATE", "INSERT", "SELECT", "TABLE", "DATABASE",
                   "<", ">", "<=", ">=", "=", "!=", "(", ")"};
    fixed_fold = '{1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0};
    fixed_cls  = '{CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD,
                   CLS_LT, CLS_GT, CLS_LE, CLS_GE, CLS_EQ, CLS_NE, CLS_LPAREN, CLS_RPAREN};
    mismatches = 0;
    checked = 0;
    foreach (class_hits[i]) class_hits[i] = 0;
    clear_statement();
  endfunction

  function void clear_statement();
    in_word = 1'b0;
    word_start = '0;
    word_len = '0;
    byte_pos = '0;
    cand = '1;
  endfunction

  function void absorb_char(logic [7:0] c);
    logic [7:0] up;
    up = (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - CASE_GAP : c;
    if (!in_word) begin
      in_word = 1'b1;
      word_start = byte_pos;
      word_len = '0;
      cand = '1;
    end
    for (int k = 0; k < N_FIXED; k++) begin
      if (cand[k]) begin
        if (word_len >= fixed_text[k].len())
          cand[k] = 1'b0;
        else if (fixed_text[k][word_len] != (fixed_fold[k] ? up : c))
          cand[k] = 1'b0;
      end
    end
    if (word_len < MAX_STMT) word_len++;
  endfunction

  function token_class_t current_class();
    for (int k = 0; k < N_FIXED; k++)
      if (cand[k] && fixed_text[k].len() == word_len) return fixed_cls[k];
    return CLS_VALUE;
  endfunction

  function void push_token(bit word, bit eos);
    token_rec_t t;
    t.cls    = word ? current_class() : CLS_NONE;
    t.start  = word ? word_start : '0;
    t.length = word ? word_len : '0;
    t.eos    = eos;
    expected_tokens.push_back(t);
  endfunction

  function void note_request(logic [7:0] c, logic last, logic empty);
    if (empty) begin
      push_token(1'b0, 1'b1);
      clear_statement();
    end else if (last) begin
      // a final semicolon or space adds nothing to the word
      if (c != CH_SEMI && c != CH_SPACE) absorb_char(c);
      push_token(in_word, 1'b1);
      clear_statement();
    end else begin
      if (c == CH_SPACE) begin
        if (in_word) begin
          push_token(1'b1, 1'b0);
          in_word = 1'b0;
          word_len = '0;
          cand = '1;
        end
      end else begin
        absorb_char(c);
      end
      if (byte_pos < MAX_STMT - 1) byte_pos++;
    end
  endfunction

  function void check_token(logic [3:0] cls, logic [11:0] start, logic [12:0] length,
                            logic eos);
    token_rec_t t;
    if (expected_tokens.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: unexpected token class %0d start %0d length %0d end %0b",
                 cls, start, length, eos);
      return;
    end
    t = expected_tokens.pop_front();
    checked++;
    if (cls !== t.cls || start !== t.start || length !== t.length || eos !== t.eos) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp class %0d start %0d length %0d end %0b, got %0d %0d %0d %0b",
                 t.cls, t.start, t.length, t.eos, cls, start, length, eos);
    end else begin
      class_hits[cls]++;
    end
  endfunction

  function int pending();
    return expected_tokens.size();
  endfunction
endclass

module tb_top;
  import swc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD = 300;
  localparam int RANDOM_ITEMS = 800;
  localparam int LONG_WORD = 4200;

  typedef logic [7:0] byte_q_t[$];

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic [7:0]  ch = '0;
  logic        is_last_byte = 1'b0;
  logic        is_empty = 1'b0;
  logic        token_stall = 1'b0;
  logic        byte_stall;
  logic        token_valid;
  logic [3:0]  token_class;
  logic [11:0] token_start;
  logic [12:0] token_length;
  logic        end_of_statement;

  token_scoreboard sb;
  int send_mode = 0;
  int recv_mode = 0;
  bit hold_req = 1'b0;
  int requests_sent = 0;
  int long_items = 0;
  int statements_sent = 0;
  int long_holds = 0;
  int idle_cycles = 0;

  sql_word_classifier u_dut (
    .clk              (clk),
    .rst              (rst),
    .byte_valid       (byte_valid),
    .byte_stall       (byte_stall),
    .ch               (ch),
    .is_last_byte     (is_last_byte),
    .is_empty         (is_empty),
    .token_valid      (token_valid),
    .token_stall      (token_stall),
    .token_class      (token_class),
    .token_start      (token_start),
    .token_length     (token_length),
    .end_of_statement (end_of_statement)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mode 0: back to back, 1: uniform gaps, 2: mostly back to back
  function automatic int draw_gap(int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 15);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
    endcase
  endfunction

  function automatic logic [7:0] any_non_space();
    logic [7:0] b;
    b = 8'($urandom_range(0, 254));
    if (b >= CH_SPACE) b = b + 8'd1;
    return b;
  endfunction

  function automatic void append_word(ref byte_q_t s);
    string kw[5] = '{"CREATE", "INSERT", "SELECT", "TABLE", "DATABASE"};
    string ops[8] = '{"<", ">", "<=", ">=", "=", "!=", "(", ")"};
    string near[8] = '{"<<", "=>", "!", "!==", "()", "<>", "==", ">=="};
    string w;
    logic [7:0] c;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind <= 2 || kind == 7) begin
      w = kw[$urandom_range(0, 4)];
      // near misses on keywords: cut short, run on, or one letter changed
      if (kind == 7) begin
        case ($urandom_range(0, 2))
          0: w = w.substr(0, $urandom_range(0, w.len() - 2));
          1: begin
            w = {w, "A"};
            w.putc(w.len() - 1, 8'($urandom_range(8'h41, 8'h5A)));
          end
          default: w.putc($urandom_range(0, w.len() - 1), 8'($urandom_range(8'h41, 8'h5A)));
        endcase
      end
      for (int i = 0; i < w.len(); i++) begin
        c = w[i];
        if (c >= 8'h41 && c <= 8'h5A && $urandom_range(0, 1)) c = c + CASE_GAP;
        s.push_back(c);
      end
    end else if (kind <= 4) begin
      w = ops[$urandom_range(0, 7)];
      for (int i = 0; i < w.len(); i++) s.push_back(w[i]);
    end else if (kind == 5) begin
      w = near[$urandom_range(0, 7)];
      for (int i = 0; i < w.len(); i++) s.push_back(w[i]);
    end else if (kind == 6) begin
      repeat ($urandom_range(1, 8)) s.push_back(any_non_space());
    end else begin
      repeat ($urandom_range(1, 12)) begin
        c = 8'($urandom_range(8'h61, 8'h7A));
        if ($urandom_range(0, 1)) c = c - CASE_GAP;
        s.push_back(c);
      end
    end
  endfunction

  task automatic send_request(logic [7:0] c, logic last, logic empty);
    int gap;
    gap = draw_gap(send_mode);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    ch <= c;
    is_last_byte <= last;
    is_empty <= empty;
    do @(posedge clk); while (byte_stall);
    sb.note_request(c, last, empty);
    requests_sent++;
  endtask

  task automatic send_text(string t);
    for (int i = 0; i < t.len(); i++) send_request(t[i], i == t.len() - 1, 1'b0);
  endtask

  task automatic send_statement();
    byte_q_t s;
    int nwords;
    int ending;
    repeat ($urandom_range(0, 2)) s.push_back(CH_SPACE);
    nwords = $urandom_range(0, 6);
    for (int i = 0; i < nwords; i++) begin
      if (i > 0) repeat ($urandom_range(1, 3)) s.push_back(CH_SPACE);
      append_word(s);
    end
    ending = $urandom_range(0, 5);
    case (ending)
      0: if (s.size() == 0 || s[s.size() - 1] == CH_SPACE) s.push_back(8'h78);
      1, 5: s.push_back(CH_SEMI);
      2: begin
        s.push_back(CH_SPACE);
        s.push_back(CH_SEMI);
      end
      3: s.push_back(CH_SPACE);
      default: ;
    endcase
    for (int i = 0; i < s.size(); i++)
      send_request(s[i], ending != 4 && i == s.size() - 1, 1'b0);
    // an empty marker ends the statement and throws away any pending word
    if (ending == 4)
      send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    statements_sent++;
  endtask

  task automatic send_noise(int n);
    logic [7:0] c;
    repeat (n) begin
      c = ($urandom_range(0, 3) == 0) ? CH_SPACE : 8'($urandom_range(0, 255));
      send_request(c, $urandom_range(0, 15) == 0, $urandom_range(0, 31) == 0);
    end
  endtask

  // drop the request line, then wait for every expected token
  task automatic wait_drained();
    byte_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // one word long enough to saturate the length, then words at the saturated position
  task automatic send_long_statement();
    int n0;
    n0 = requests_sent;
    send_mode = 2;
    repeat (LONG_WORD) send_request(any_non_space(), 1'b0, 1'b0);
    send_text(" ab sElecT");
    long_items += requests_sent - n0;
    statements_sent++;
  endtask

  task automatic send_burst();
    hold_req = 1'b1;
    send_mode = 0;
    repeat (40) begin
      send_request(8'($urandom_range(8'h61, 8'h7A)), 1'b0, 1'b0);
      send_request(CH_SPACE, 1'b0, 1'b0);
    end
    send_request(8'h7A, 1'b1, 1'b0);
    statements_sent++;
  endtask

  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (token_valid && !token_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d tokens outstanding",
               idle_cycles, sb.pending());
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side
  initial begin
    int wait_cycles;
    int rx_count;
    rx_count = 0;
    wait (rst == 1'b0);
    forever begin
      if (rx_count % 40 == 0) recv_mode = $urandom_range(0, 2);
      if (hold_req) begin
        hold_req = 1'b0;
        wait_cycles = LONG_HOLD;
        long_holds++;
      end else begin
        wait_cycles = draw_gap(recv_mode);
      end
      if (wait_cycles > 0) begin
        token_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      token_stall <= 1'b0;
      do @(posedge clk); while (!token_valid);
      sb.check_token(token_class, token_start, token_length, end_of_statement);
      rx_count++;
    end
  end

  // request side
  initial begin
    bit burst_done;
    bit long_done;
    burst_done = 1'b0;
    long_done = 1'b0;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_mode = 1;
    send_request(8'hFF, 1'b1, 1'b1);
    send_text("<= > >= = != ( ) <;");
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'hFF, 1'b0, 1'b0);
    send_request(8'h5A, 1'b0, 1'b1);
    wait_drained();

    while (requests_sent - long_items < RANDOM_ITEMS + 25) begin
      send_mode = $urandom_range(0, 2);
      if ($urandom_range(0, 99) < 8) send_noise($urandom_range(1, 12));
      else send_statement();
      if ($urandom_range(0, 19) == 0) wait_drained();
      if (!burst_done && requests_sent > 200) begin
        send_burst();
        wait_drained();
        burst_done = 1'b1;
      end
      if (!long_done && requests_sent - long_items > 400) begin
        send_long_statement();
        long_done = 1'b1;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);

    $display("summary: %0d requests over %0d statements, %0d tokens checked, %0d long holds",
             requests_sent, statements_sent, sb.checked, long_holds);
    $display("summary: none %0d keyword %0d value %0d operator/paren %0d, %0d mismatches",
             sb.class_hits[CLS_NONE], sb.class_hits[CLS_KEYWORD], sb.class_hits[CLS_VALUE],
             sb.checked - sb.class_hits[CLS_NONE] - sb.class_hits[CLS_KEYWORD]
               - sb.class_hits[CLS_VALUE] - sb.mismatches,
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/swc_pkg.sv
rtl/swc_match.sv
rtl/sql_word_classifier.sv
tb/tb_top.sv
